>>> hw/rtl/lrx_pkg.sv
package lrx_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned ADDR_W        = 18;
  localparam int unsigned BUFFER_DEPTH  = 1 << ADDR_W;
  localparam int unsigned BIN_W         = 7;
  localparam int unsigned OVERVIEW_BINS = 1 << BIN_W;
  localparam int unsigned BIN_POS_LO    = ADDR_W - BIN_W;
  localparam int unsigned SUM_W         = 27;
  localparam int unsigned BIN_SHIFT     = 11;
  localparam int unsigned STEP_W        = 7;
  localparam int unsigned FADE_LEN      = 100;

  // crossfade divide by FADE_LEN+1 as a reciprocal multiply, exact below 2^MAG_W
  localparam int unsigned FADE_DIV  = FADE_LEN + 1;
  localparam int unsigned FADE_HALF = FADE_DIV / 2;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned DIV_SHIFT = MAG_W + $clog2(FADE_DIV);
  localparam int unsigned RECIP_W   = MAG_W + 1;
  localparam longint unsigned RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(FADE_DIV) - 64'd1) / 64'(FADE_DIV);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_TOGGLE    = 2'd1,
    CMD_RD_SAMPLE = 2'd2,
    CMD_RD_BIN    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ISSUE,
    ST_EVAL,
    ST_DIV
  } back_state_e;

  typedef struct packed {
    cmd_e                       op;
    logic signed [SAMPLE_W-1:0] audio;
    logic [ADDR_W-1:0]          addr;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

endpackage

>>> hw/rtl/lrx_ram.sv
module lrx_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lrx_front.sv
module lrx_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic signed [lrx_pkg::SAMPLE_W-1:0] audio_in_i,
  input  logic [lrx_pkg::ADDR_W-1:0]          read_address_i,
  output lrx_pkg::queue_t                     head_o,
  input  logic                                pop_i
);
  import lrx_pkg::*;

  item_t            fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  item_t            item;

  always_comb begin
    item.op    = cmd_e'(command_i);
    item.audio = audio_in_i;
    item.addr  = read_address_i;
  end

  assign in_stall_o = (count_q == CNT_W'(FIFO_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = fifo_q[rd_ptr_q];

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("queue count overflow");

endmodule

>>> hw/rtl/lrx_back.sv
module lrx_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lrx_pkg::queue_t                     head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lrx_pkg::SAMPLE_W-1:0] read_data_o,
  output logic                                recording_active_o,
  output logic                                stopping_active_o,
  output logic [lrx_pkg::ADDR_W-1:0]          write_position_o
);
  import lrx_pkg::*;

  back_state_e state_q, state_d;

  // transaction under execution
  cmd_e                 op_q;
  logic [SAMPLE_W-1:0]  audio_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [BIN_W-1:0]     bin_q;

  // recorder state
  logic [ADDR_W-1:0]        wp_q, wp_d;
  logic                     wrapped_q, wrapped_d;
  logic [STEP_W-1:0]        fade_q, fade_d;
  logic                     rec_q, rec_d;
  logic                     stop_q, stop_d;
  logic [BIN_W-1:0]         last_bin_q, last_bin_d;
  logic [OVERVIEW_BINS-1:0] bin_valid_q;

  // crossfade stage
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic                neg_q;
  logic [SAMPLE_W-1:0] old_q;

  // result register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q, out_data_d;
  logic                out_rec_q, out_stop_q;
  logic [ADDR_W-1:0]   out_wp_q;

  logic is_tick, rec_tick, need_blend, out_free;
  logic finish, blend_load;
  logic samp_we, bin_we;

  logic [ADDR_W-1:0]   head_samp_addr, samp_raddr;
  logic [BIN_W-1:0]    head_bin, bin_raddr;
  logic [SAMPLE_W-1:0] samp_rdata, samp_wdata, old_eff;
  logic [SUM_W-1:0]    sum_rdata, sum_wdata, old_sum, bin_word;

  logic [SAMPLE_W:0]         diff, diff_mag;
  logic [STEP_W:0]           step_k;
  logic [SAMPLE_W+STEP_W+1:0] prod;
  logic [MAG_W+RECIP_W-1:0]  quot_full;
  logic [SAMPLE_W:0]         quot, quot_signed, blend_sum;
  logic [SAMPLE_W-1:0]       blended;
  logic [SAMPLE_W:0]         audio_mag;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W-BIN_SHIFT-1:0] bin_scaled;
  logic [SAMPLE_W-1:0]       bin_read;
  logic                      bin_clear, rd_valid;

  assign is_tick    = (op_q == CMD_TICK);
  assign rec_tick   = is_tick && rec_q;
  assign need_blend = rec_tick && (stop_q || (fade_q < STEP_W'(FADE_LEN)));
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ISSUE: if (head_i.valid) state_d = ST_EVAL;
      ST_EVAL: begin
        if (need_blend) begin
          state_d = ST_DIV;
        end else if (out_free) begin
          state_d = ST_ISSUE;
        end
      end
      ST_DIV:  if (out_free) state_d = ST_ISSUE;
      default: state_d = ST_ISSUE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    finish     = 1'b0;
    blend_load = 1'b0;
    unique case (state_q)
      ST_ISSUE: pop_o = head_i.valid;
      ST_EVAL: begin
        blend_load = need_blend;
        finish     = !need_blend && out_free;
      end
      ST_DIV:  finish = out_free;
      default: ;
    endcase
  end

  assign samp_we = finish && is_tick;
  assign bin_we  = finish && rec_tick;

  // memory read addresses: from the queue head at issue, held afterwards
  assign head_samp_addr = (head_i.item.op == CMD_TICK) ? wp_q : head_i.item.addr;
  assign head_bin = (head_i.item.op == CMD_TICK) ? wp_q[ADDR_W-1:BIN_POS_LO]
                                                 : head_i.item.addr[BIN_W-1:0];
  assign samp_raddr = (state_q == ST_ISSUE) ? head_samp_addr : addr_q;
  assign bin_raddr  = (state_q == ST_ISSUE) ? head_bin : bin_q;

  lrx_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (samp_we),
    .waddr_i (addr_q),
    .wdata_i (samp_wdata),
    .raddr_i (samp_raddr),
    .rdata_o (samp_rdata)
  );

  lrx_ram #(
    .WIDTH (SUM_W),
    .DEPTH (OVERVIEW_BINS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_q),
    .wdata_i (sum_wdata),
    .raddr_i (bin_raddr),
    .rdata_o (sum_rdata)
  );

  // entries at or above the write head were never written until the first wrap
  assign old_eff  = wrapped_q ? samp_rdata : '0;
  assign rd_valid = wrapped_q || (addr_q < wp_q);

  // crossfade: |in - old| * (step+1) + half, then reciprocal multiply
  always_comb begin
    diff     = {audio_q[SAMPLE_W-1], audio_q} - {old_eff[SAMPLE_W-1], old_eff};
    diff_mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    step_k   = {1'b0, fade_q} + 1'b1;
    prod     = (SAMPLE_W+STEP_W+2)'(diff_mag) * (SAMPLE_W+STEP_W+2)'(step_k);
    mag_d    = prod[MAG_W-1:0] + MAG_W'(FADE_HALF);
  end

  always_comb begin
    quot_full   = (MAG_W+RECIP_W)'(mag_q) * (MAG_W+RECIP_W)'(RECIP);
    quot        = quot_full[DIV_SHIFT +: SAMPLE_W+1];
    quot_signed = neg_q ? (~quot + 1'b1) : quot;
    blend_sum   = {old_q[SAMPLE_W-1], old_q} + quot_signed;
    blended     = blend_sum[SAMPLE_W-1:0];
  end

  always_comb begin
    if (state_q == ST_DIV) begin
      samp_wdata = blended;
    end else if (rec_q) begin
      samp_wdata = audio_q;
    end else begin
      samp_wdata = old_eff;
    end
  end

  // overview bin accumulate with saturation
  always_comb begin
    bin_clear = (wp_q == '0) || (bin_q > last_bin_q) || !bin_valid_q[bin_q];
    old_sum   = bin_clear ? '0 : sum_rdata;
    audio_mag = audio_q[SAMPLE_W-1] ? (~{1'b1, audio_q} + 1'b1) : {1'b0, audio_q};
    sum_ext   = {1'b0, old_sum} + (SUM_W+1)'(audio_mag);
    sum_wdata = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  always_comb begin
    bin_word   = bin_valid_q[bin_q] ? sum_rdata : '0;
    bin_scaled = bin_word[SUM_W-1:BIN_SHIFT];
    bin_read   = bin_scaled[SAMPLE_W-1] ? {1'b0, {(SAMPLE_W-1){1'b1}}} : bin_scaled;
  end

  always_comb begin
    case (op_q)
      CMD_RD_SAMPLE: out_data_d = rd_valid ? samp_rdata : '0;
      CMD_RD_BIN:    out_data_d = bin_read;
      default:       out_data_d = '0;
    endcase
  end

  // recorder state after this transaction
  always_comb begin
    wp_d       = wp_q;
    wrapped_d  = wrapped_q;
    fade_d     = fade_q;
    rec_d      = rec_q;
    stop_d     = stop_q;
    last_bin_d = last_bin_q;
    if (is_tick) begin
      wp_d = wp_q + 1'b1;
      if (wp_q == '1) wrapped_d = 1'b1;
      if (rec_q) begin
        last_bin_d = bin_q;
        if (stop_q) begin
          fade_d = fade_q - 1'b1;
          if (fade_d == '0) begin
            rec_d  = 1'b0;
            stop_d = 1'b0;
          end
        end else if (fade_q < STEP_W'(FADE_LEN)) begin
          fade_d = fade_q + 1'b1;
        end
      end
    end else if (op_q == CMD_TOGGLE) begin
      if (!rec_q) begin
        rec_d  = 1'b1;
        stop_d = 1'b0;
        fade_d = '0;
      end else if (!stop_q) begin
        // stop at step zero ends recording without a fade-out
        if (fade_q == '0) begin
          rec_d = 1'b0;
        end else begin
          stop_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ISSUE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      fade_q      <= '0;
      rec_q       <= 1'b1;
      stop_q      <= 1'b0;
      last_bin_q  <= '0;
      bin_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        wp_q       <= wp_d;
        wrapped_q  <= wrapped_d;
        fade_q     <= fade_d;
        rec_q      <= rec_d;
        stop_q     <= stop_d;
        last_bin_q <= last_bin_d;
      end
      if (bin_we) begin
        bin_valid_q[bin_q] <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q    <= head_i.item.op;
      audio_q <= head_i.item.audio;
      addr_q  <= head_samp_addr;
      bin_q   <= head_bin;
    end
    if (blend_load) begin
      mag_q <= mag_d;
      neg_q <= diff[SAMPLE_W];
      old_q <= old_eff;
    end
    if (finish) begin
      out_data_q <= out_data_d;
      out_rec_q  <= rec_d;
      out_stop_q <= stop_d;
      out_wp_q   <= wp_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = out_data_q;
  assign recording_active_o = out_rec_q;
  assign stopping_active_o  = out_stop_q;
  assign write_position_o   = out_wp_q;

  a_stop_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> rec_q && (fade_q != '0))
    else $error("fade-out without recording or at step zero");

  a_fade_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_q <= STEP_W'(FADE_LEN))
    else $error("fade step beyond fade length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && out_valid_q |-> !out_stall_i)
    else $error("result register overwritten while stalled");

  a_pop_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_EVAL)
    else $error("popped transaction not evaluated");

endmodule

>>> hw/rtl/looper_record_crossfade.sv
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   command_i, audio_in_i, read_address_i
// out      output     out_valid_o / out_stall_i read_data_o, recording_active_o,
//                                               stopping_active_o, write_position_o
//
// each transaction is a memory read, then evaluate and write back; a tick that crossfades
// adds a divide state, as the reciprocal multiply of the blend takes its own stage.
// a 2-entry queue takes transactions while the back end works or the output stalls.
// reset needs no clearing pass: samples above the write head read as zero until the
// first wrap, and each overview bin has a valid bit. recording is active after reset.
module looper_record_crossfade (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic signed [lrx_pkg::SAMPLE_W-1:0] audio_in_i,
  input  logic [lrx_pkg::ADDR_W-1:0]          read_address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lrx_pkg::SAMPLE_W-1:0] read_data_o,
  output logic                                recording_active_o,
  output logic                                stopping_active_o,
  output logic [lrx_pkg::ADDR_W-1:0]          write_position_o
);
  import lrx_pkg::*;

  queue_t head;
  logic   pop;

  lrx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .audio_in_i     (audio_in_i),
    .read_address_i (read_address_i),
    .head_o         (head),
    .pop_i          (pop)
  );

  lrx_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_data_o        (read_data_o),
    .recording_active_o (recording_active_o),
    .stopping_active_o  (stopping_active_o),
    .write_position_o   (write_position_o)
  );

endmodule

>>> tb/sv/tb_looper_record_crossfade.sv
module tb_looper_record_crossfade;
  import lrx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 200;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 16'sh8000;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] data;
    logic                       rec;
    logic                       stop;
    logic [ADDR_W-1:0]          pos;
  } looper_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 command_i = '0;
  logic signed [SAMPLE_W-1:0] audio_in_i = '0;
  logic [ADDR_W-1:0]          read_address_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] read_data_o;
  logic                       recording_active_o;
  logic                       stopping_active_o;
  logic [ADDR_W-1:0]          write_position_o;

  looper_record_crossfade dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .audio_in_i         (audio_in_i),
    .read_address_i     (read_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_data_o        (read_data_o),
    .recording_active_o (recording_active_o),
    .stopping_active_o  (stopping_active_o),
    .write_position_o   (write_position_o)
  );

  // shadow copy of the recorder
  logic signed [SAMPLE_W-1:0] mem_model [0:BUFFER_DEPTH-1];
  logic [SUM_W-1:0]           bin_model [0:OVERVIEW_BINS-1];
  logic [ADDR_W-1:0]          head_pos;
  logic [STEP_W-1:0]          fade_cnt;
  logic                       rec_on;
  logic                       fading_out;
  logic [BIN_W-1:0]           last_bin_seen;

  item_t          pending_items [$];
  looper_result_t expected_results [$];
  item_t          cur_item, next_item;
  looper_result_t want;
  logic [ADDR_W-1:0] plan_wp;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_accepted = 0, n_checked = 0, n_errors = 0;
  int unsigned n_ticks = 0, n_toggles = 0, n_reads = 0, n_wraps = 0;
  int unsigned cycle_cnt = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [SAMPLE_W-1:0] crossfade_sample(
      logic signed [SAMPLE_W-1:0] old_s, logic signed [SAMPLE_W-1:0] new_s,
      logic [STEP_W-1:0] step);
    longint num, mag, q;
    num = (longint'(new_s) - longint'(old_s)) * (longint'(step) + 1);
    mag = (num < 0) ? -num : num;
    // round half away from zero
    q = (mag + longint'(FADE_HALF)) / longint'(FADE_DIV);
    if (num < 0) q = -q;
    return SAMPLE_W'(longint'(old_s) + q);
  endfunction

  function automatic looper_result_t predict_looper(item_t it);
    looper_result_t r;
    logic signed [SAMPLE_W-1:0] smp;
    logic [BIN_W-1:0] bin;
    logic [SUM_W:0] sum;
    logic [SUM_W-1:0] scaled;
    smp = it.audio;
    r.data = '0;
    case (it.op)
      CMD_TICK: begin
        n_ticks++;
        if (rec_on) begin
          if (fading_out) begin
            mem_model[head_pos] = crossfade_sample(mem_model[head_pos], smp, fade_cnt);
            fade_cnt = fade_cnt - 1'b1;
            if (fade_cnt == 0) begin
              rec_on = 1'b0;
              fading_out = 1'b0;
            end
          end else if (fade_cnt < FADE_LEN) begin
            mem_model[head_pos] = crossfade_sample(mem_model[head_pos], smp, fade_cnt);
            fade_cnt = fade_cnt + 1'b1;
          end else begin
            mem_model[head_pos] = smp;
          end
          bin = head_pos[ADDR_W-1:BIN_POS_LO];
          // a bin restarts when the head first enters it
          if (head_pos == 0 || bin > last_bin_seen) bin_model[bin] = '0;
          sum = (SUM_W+1)'(bin_model[bin]) + (SUM_W+1)'((smp < 0) ? -int'(smp) : int'(smp));
          bin_model[bin] = (sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
          last_bin_seen = bin;
        end
        head_pos = head_pos + 1'b1;
        if (head_pos == 0) n_wraps++;
      end
      CMD_TOGGLE: begin
        n_toggles++;
        if (!rec_on) begin
          rec_on = 1'b1;
          fading_out = 1'b0;
          fade_cnt = '0;
        end else if (!fading_out) begin
          // stop at step zero ends recording without a fade-out
          if (fade_cnt == 0) rec_on = 1'b0;
          else fading_out = 1'b1;
        end
      end
      CMD_RD_SAMPLE: begin
        n_reads++;
        r.data = mem_model[it.addr];
      end
      default: begin
        n_reads++;
        scaled = bin_model[it.addr[BIN_W-1:0]] >> BIN_SHIFT;
        r.data = (scaled > SUM_W'(SAMPLE_TOP)) ? SAMPLE_TOP : SAMPLE_W'(scaled);
      end
    endcase
    r.rec = rec_on;
    r.stop = fading_out;
    r.pos = head_pos;
    return r;
  endfunction

  task automatic add_item(cmd_e op, logic signed [SAMPLE_W-1:0] smp, logic [ADDR_W-1:0] addr);
    item_t it;
    it.op = op;
    it.audio = smp;
    it.addr = addr;
    pending_items.push_back(it);
    if (op == CMD_TICK) plan_wp = plan_wp + 1'b1;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_audio();
    case ($urandom_range(15))
      0: return SAMPLE_TOP;
      1: return SAMPLE_BOTTOM;
      2: return '0;
      3: return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic add_random_read();
    logic [ADDR_W-1:0] addr;
    case ($urandom_range(3))
      0, 1: addr = plan_wp - ADDR_W'($urandom_range(256));
      2: addr = ADDR_W'($urandom);
      default: addr = $urandom_range(1) ? ADDR_TOP : '0;
    endcase
    add_item($urandom_range(2) == 0 ? CMD_RD_BIN : CMD_RD_SAMPLE, SAMPLE_W'($urandom), addr);
  endtask

  // bursts of ticks with reads mixed in, separated by toggles and reads
  task automatic gen_random(int unsigned n_items);
    int unsigned made, run_len, r;
    made = 0;
    plan_wp = head_pos;
    while (made < n_items) begin
      r = $urandom_range(99);
      if (r < 40) begin
        run_len = $urandom_range(120, 1);
        repeat (run_len) begin
          if ($urandom_range(5) == 0) begin
            add_random_read();
            made++;
          end
          add_item(CMD_TICK, pick_audio(), ADDR_W'($urandom));
          made++;
        end
      end else if (r < 60) begin
        add_item(CMD_TOGGLE, SAMPLE_W'($urandom), ADDR_W'($urandom));
        made++;
      end else begin
        add_random_read();
        made++;
      end
    end
  endtask

  // checked between edges so that the driver's updates have settled
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic report_mismatch(string field, longint want_v, longint got_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur_item.op = cmd_e'(command_i);
        cur_item.audio = audio_in_i;
        cur_item.addr = read_address_i;
        expected_results.push_back(predict_looper(cur_item));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          command_i <= next_item.op;
          audio_in_i <= next_item.audio;
          read_address_i <= next_item.addr;
        end else begin
          in_valid_i <= 1'b0;
          command_i <= 2'($urandom);
          audio_in_i <= SAMPLE_W'($urandom);
          read_address_i <= ADDR_W'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result with no transaction outstanding, expected none, actual %0d",
                     $time, read_data_o);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (read_data_o !== want.data)
            report_mismatch("read_data", longint'(want.data), longint'(read_data_o));
          if (recording_active_o !== want.rec)
            report_mismatch("recording_active", want.rec, recording_active_o);
          if (stopping_active_o !== want.stop)
            report_mismatch("stopping_active", want.stop, stopping_active_o);
          if (write_position_o !== want.pos)
            report_mismatch("write_position", want.pos, write_position_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycle_cnt,
             expected_results.size());
    $display("[looper_record_crossfade] ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < BUFFER_DEPTH; i++) mem_model[i] = '0;
    for (int i = 0; i < OVERVIEW_BINS; i++) bin_model[i] = '0;
    head_pos = '0;
    fade_cnt = '0;
    rec_on = 1'b1;
    fading_out = 1'b0;
    last_bin_seen = '0;
    plan_wp = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty reads, extreme samples during fade-in, toggle during
    // fade-out, fade-out to the end, idle tick, stop at step zero
    add_item(CMD_RD_SAMPLE, SAMPLE_TOP, '0);
    add_item(CMD_RD_BIN, SAMPLE_BOTTOM, '0);
    add_item(CMD_TICK, SAMPLE_TOP, ADDR_TOP);
    add_item(CMD_TICK, SAMPLE_BOTTOM, '0);
    add_item(CMD_TICK, '0, ADDR_TOP);
    add_item(CMD_TICK, -16'sd1, '0);
    add_item(CMD_TICK, 16'sd1, '0);
    add_item(CMD_TOGGLE, SAMPLE_TOP, ADDR_TOP);
    add_item(CMD_TOGGLE, '0, '0);
    add_item(CMD_TICK, SAMPLE_TOP, '0);
    add_item(CMD_TICK, SAMPLE_BOTTOM, '0);
    add_item(CMD_TICK, 16'sh5555, '0);
    add_item(CMD_TICK, 16'shAAAA, '0);
    add_item(CMD_TICK, SAMPLE_BOTTOM, '0);
    add_item(CMD_TICK, 16'sd1000, '0);
    add_item(CMD_RD_SAMPLE, '0, 18'd1);
    add_item(CMD_RD_SAMPLE, '0, ADDR_TOP);
    add_item(CMD_RD_BIN, '0, ADDR_TOP);
    add_item(CMD_TOGGLE, '0, '0);
    add_item(CMD_TOGGLE, '0, '0);
    add_item(CMD_TOGGLE, '0, '0);
    add_item(CMD_TICK, SAMPLE_TOP, '0);
    add_item(CMD_RD_BIN, '0, 18'd128);
    add_item(CMD_RD_SAMPLE, '0, 18'd15);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      gen_random(490);
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions: %0d ticks, %0d toggles, %0d reads, %0d buffer wraps",
             n_accepted, n_ticks, n_toggles, n_reads, n_wraps);
    $display("%0d results checked under four idle/stall mixes, %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0) begin
      $display("[looper_record_crossfade] OK");
    end else begin
      $display("[looper_record_crossfade] ERROR");
    end
    $finish;
  end

endmodule
